@@ rtl/cse_pkg.sv @@
package cse_pkg;

	localparam int KEY_W         = 8;
	localparam int DEF_MAX_ITEMS = 64;
	localparam int DEF_KEY_BITS  = 8;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_DRAIN,
		ST_SCAN,
		ST_PLACE_ITEM,
		ST_PLACE_HIST,
		ST_PLACE_WR,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_open;
		logic scan_rd;
		logic place_item_rd;
		logic place_hist_rd;
		logic place_wr;
		logic emit_en;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic batch_done;
		logic load_busy;
		logic scan_last;
		logic place_last;
		logic emit_done;
	} stat_t;

endpackage

@@ rtl/counting_sort_engine.sv @@
// channel   | handshake             | payload
// key       | key_valid, key_stall  | key_value, batch_end
// sort      | sort_valid, sort_stall| sorted_key, final_result, items_dropped
//
// Keys load at one per cycle; the histogram increment is forwarded between adjacent keys.
// After the last key: drain for the last increment, running sums over all entries,
// placement (item read, histogram read, write; one hist port), then one result per cycle.
// Reset clears the histogram valid flags at once; there is no clearing pass.
// key_stall is high outside loading; a stalled result holds in the output register.
module counting_sort_engine #(
	parameter int MAX_ITEMS = cse_pkg::DEF_MAX_ITEMS,
	parameter int KEY_BITS  = cse_pkg::DEF_KEY_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [cse_pkg::KEY_W-1:0] key_value,
	input  logic                      batch_end,
	input  logic                      key_valid,
	output logic                      key_stall,
	output logic [cse_pkg::KEY_W-1:0] sorted_key,
	output logic                      final_result,
	output logic                      items_dropped,
	output logic                      sort_valid,
	input  logic                      sort_stall
);

	cse_pkg::cmd_t  cmd;
	cse_pkg::stat_t stat;

	cse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	cse_datapath #(
		.MAX_ITEMS (MAX_ITEMS),
		.KEY_BITS  (KEY_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.key_value     (key_value),
		.batch_end     (batch_end),
		.key_valid     (key_valid),
		.sorted_key    (sorted_key),
		.final_result  (final_result),
		.items_dropped (items_dropped),
		.sort_valid    (sort_valid),
		.sort_stall    (sort_stall),
		.cmd           (cmd),
		.stat          (stat)
	);

	assign key_stall = !cmd.load_open;

endmodule

@@ rtl/cse_ctrl.sv @@
module cse_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  cse_pkg::stat_t stat,
	output cse_pkg::cmd_t  cmd
);

	cse_pkg::state_t state_q;
	cse_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cse_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cse_pkg::ST_LOAD: begin
				if (stat.batch_done) state_d = cse_pkg::ST_DRAIN;
			end
			cse_pkg::ST_DRAIN: begin
				if (!stat.load_busy) state_d = cse_pkg::ST_SCAN;
			end
			cse_pkg::ST_SCAN: begin
				if (stat.scan_last) state_d = cse_pkg::ST_PLACE_ITEM;
			end
			cse_pkg::ST_PLACE_ITEM: begin
				state_d = cse_pkg::ST_PLACE_HIST;
			end
			cse_pkg::ST_PLACE_HIST: begin
				state_d = cse_pkg::ST_PLACE_WR;
			end
			cse_pkg::ST_PLACE_WR: begin
				state_d = stat.place_last ? cse_pkg::ST_EMIT : cse_pkg::ST_PLACE_ITEM;
			end
			cse_pkg::ST_EMIT: begin
				if (stat.emit_done) state_d = cse_pkg::ST_LOAD;
			end
			default: begin
				state_d = cse_pkg::ST_LOAD;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			cse_pkg::ST_LOAD:       cmd.load_open     = 1'b1;
			cse_pkg::ST_DRAIN:      cmd               = '0;
			cse_pkg::ST_SCAN:       cmd.scan_rd       = 1'b1;
			cse_pkg::ST_PLACE_ITEM: cmd.place_item_rd = 1'b1;
			cse_pkg::ST_PLACE_HIST: cmd.place_hist_rd = 1'b1;
			cse_pkg::ST_PLACE_WR:   cmd.place_wr      = 1'b1;
			cse_pkg::ST_EMIT: begin
				cmd.emit_en = 1'b1;
				cmd.clear   = stat.emit_done;
			end
			default:                cmd               = '0;
		endcase
	end

endmodule

@@ rtl/cse_datapath.sv @@
module cse_datapath #(
	parameter int MAX_ITEMS = cse_pkg::DEF_MAX_ITEMS,
	parameter int KEY_BITS  = cse_pkg::DEF_KEY_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [cse_pkg::KEY_W-1:0] key_value,
	input  logic                      batch_end,
	input  logic                      key_valid,
	output logic [cse_pkg::KEY_W-1:0] sorted_key,
	output logic                      final_result,
	output logic                      items_dropped,
	output logic                      sort_valid,
	input  logic                      sort_stall,
	input  cse_pkg::cmd_t             cmd,
	output cse_pkg::stat_t            stat
);

	localparam int KW = cse_pkg::KEY_W;
	localparam int HB = (KEY_BITS < KW) ? KEY_BITS : KW;
	localparam int HD = 1 << HB;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int IW = $clog2(MAX_ITEMS);
	localparam logic [KW-1:0] KEY_MASK = KW'((1 << HB) - 1);

	logic [KW-1:0] item_mem   [MAX_ITEMS];
	logic [KW-1:0] placed_mem [MAX_ITEMS];
	logic [CW-1:0] hist_mem   [HD];
	logic [HD-1:0] hist_vld_q;

	logic [CW-1:0] cnt_q, pi_q, em_q, sum_q, fwd_cnt_q, hist_rd_q;
	logic          ovf_q, hv_rd_q, fwd_vld_q, inc_vld_s1, scan_vld_s1, out_vld_q;
	logic [HB-1:0] inc_key_s1, scan_key_s1, scan_idx_q, fwd_key_q, rd_addr, wr_addr;
	logic [KW-1:0] key_m, item_rd_q, out_key_q;
	logic          out_final_q, out_drop_q;
	logic [CW-1:0] wr_data, hist_eff, inc_base, pi_m1, pos;
	logic          acc, store, wr_en, rd_en, out_load;

	assign key_m    = key_value & KEY_MASK;
	assign acc      = key_valid && cmd.load_open;
	assign store    = acc && (cnt_q < CW'(MAX_ITEMS));
	assign hist_eff = hv_rd_q ? hist_rd_q : '0;
	assign inc_base = (fwd_vld_q && (fwd_key_q == inc_key_s1)) ? fwd_cnt_q : hist_eff;
	assign pi_m1    = pi_q - CW'(1);
	assign pos      = hist_rd_q - CW'(1);
	assign out_load = cmd.emit_en && (em_q < cnt_q) && (!out_vld_q || !sort_stall);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = key_m[HB-1:0];
		priority if (cmd.scan_rd) begin
			rd_en   = 1'b1;
			rd_addr = scan_idx_q;
		end else if (cmd.place_hist_rd) begin
			rd_en   = 1'b1;
			rd_addr = item_rd_q[HB-1:0];
		end else begin
			rd_en   = store;
			rd_addr = key_m[HB-1:0];
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		priority if (inc_vld_s1) begin
			wr_en   = 1'b1;
			wr_addr = inc_key_s1;
			wr_data = inc_base + CW'(1);
		end else if (scan_vld_s1) begin
			wr_en   = 1'b1;
			wr_addr = scan_key_s1;
			wr_data = hist_eff + sum_q;
		end else if (cmd.place_wr) begin
			wr_en   = 1'b1;
			wr_addr = item_rd_q[HB-1:0];
			wr_data = pos;
		end else begin
			wr_en   = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (store) item_mem[cnt_q[IW-1:0]] <= key_m;
		if (cmd.place_item_rd) item_rd_q <= item_mem[pi_m1[IW-1:0]];
		if (rd_en) begin
			hist_rd_q <= hist_mem[rd_addr];
			hv_rd_q   <= hist_vld_q[rd_addr];
		end
		if (wr_en) hist_mem[wr_addr] <= wr_data;
		if (cmd.place_wr) placed_mem[pos[IW-1:0]] <= item_rd_q;
		if (store) inc_key_s1 <= key_m[HB-1:0];
		if (cmd.scan_rd) scan_key_s1 <= scan_idx_q;
		if (inc_vld_s1) begin
			fwd_key_q <= inc_key_s1;
			fwd_cnt_q <= wr_data;
		end
		if (out_load) begin
			out_key_q   <= placed_mem[em_q[IW-1:0]];
			out_final_q <= (em_q == (cnt_q - CW'(1)));
			out_drop_q  <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			inc_vld_s1  <= 1'b0;
			scan_vld_s1 <= 1'b0;
			scan_idx_q  <= '0;
			sum_q       <= '0;
			pi_q        <= '0;
			em_q        <= '0;
			out_vld_q   <= 1'b0;
			hist_vld_q  <= '0;
			fwd_vld_q   <= 1'b0;
		end else begin
			inc_vld_s1  <= store;
			scan_vld_s1 <= cmd.scan_rd;
			if (store) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (acc) begin
				ovf_q <= 1'b1;
			end
			if (wr_en) hist_vld_q[wr_addr] <= 1'b1;
			if (inc_vld_s1) fwd_vld_q <= 1'b1;
			if (cmd.scan_rd) begin
				scan_idx_q <= scan_idx_q + HB'(1);
				pi_q       <= cnt_q;
			end
			if (scan_vld_s1) sum_q <= hist_eff + sum_q;
			if (cmd.place_wr) pi_q <= pi_m1;
			if (out_load) begin
				out_vld_q <= 1'b1;
				em_q      <= em_q + CW'(1);
			end else if (!sort_stall) begin
				out_vld_q <= 1'b0;
			end
			if (cmd.clear) begin
				cnt_q      <= '0;
				ovf_q      <= 1'b0;
				hist_vld_q <= '0;
				fwd_vld_q  <= 1'b0;
				sum_q      <= '0;
				em_q       <= '0;
			end
		end
	end

	always_comb begin
		stat.batch_done = acc && batch_end;
		stat.load_busy  = inc_vld_s1;
		stat.scan_last  = (scan_idx_q == '1);
		stat.place_last = (pi_q == CW'(1));
		stat.emit_done  = (em_q == cnt_q) && (!out_vld_q || !sort_stall);
	end

	assign sorted_key    = out_key_q;
	assign final_result  = out_final_q;
	assign items_dropped = out_drop_q;
	assign sort_valid    = out_vld_q;

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_final_q && !sort_stall |=> cnt_q == '0)
		else $error("batch not cleared after final transfer");

	a_pos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.place_wr |-> hist_rd_q != '0)
		else $error("placement position underflow");

	a_wr_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(inc_vld_s1 && scan_vld_s1))
		else $error("histogram write collision");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ITEMS))
		else $error("item count beyond capacity");

	a_emit_started: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> em_q != '0)
		else $error("result shown before any read");

endmodule
